>>> rtl/core/trpd_pkg.sv
// Package with the shared types and constants of the TGA run-length pixel decoder.
`default_nettype none

package trpd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FOUR_BYTE = 2'd0;
  localparam logic [1:0] CFG_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_HEIGHT    = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Default depth of the queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Packet header decoding: a set top bit marks a run packet.
  localparam logic [7:0] RAW_BIAS = 8'd1;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // One assembled pixel with the packet context needed to form its result.
  typedef struct packed {
    logic [31:0] pixel;
    logic        run_packet;
    logic [7:0]  packet_left;
    logic        last;
    logic [7:0]  remain_low;
  } pixel_entry_t;

endpackage : trpd_pkg

`default_nettype wire

>>> rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder.
`default_nettype none

// Decodes the pixel stream of a run-length coded TGA image (24 or 32 bits per pixel), taking one
// byte per request on the push side in every clock cycle while full is low, with no wait after
// headers or pixels. Each raw pixel leaves as one result with repeat count 1 and each run packet
// leaves as a single result carrying its repeat count, clipped to the pixels still missing from
// the image; the result that completes the image has last_of_image set and the pixel count
// restarts. A result passes from the queue into the result register once that register is free.
// Between the parser and the result register sits a queue of QUEUE_DEPTH pixels, so full rises
// only when the consumer has left that many pixels plus the one on the result ports untaken.
// Configuration is to be written only while no results are pending; the block does not enforce
// this. Writing the width or height refreshes the pixel total with one 16 by 16 multiply.
module tga_rle_pixel_decoder
  import trpd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = trpd_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             data_byte,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [31:0]                 pixel_value,
  output logic [7:0]                  repeat_count,
  output logic                        last_of_image,
  output logic                        overran
);

  logic         q_push;
  pixel_entry_t q_wr_entry;
  logic         q_valid;
  logic         q_take;
  pixel_entry_t q_rd_entry;

  // Parser and pixel assembly.
  trpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .q_push    (q_push),
    .q_entry   (q_wr_entry)
  );

  // Pixel queue.
  trpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .full     (full),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_entry (q_rd_entry)
  );

  // Result formation and output register.
  trpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_take        (q_take),
    .q_entry       (q_rd_entry),
    .pop           (pop),
    .empty         (empty),
    .pixel_value   (pixel_value),
    .repeat_count  (repeat_count),
    .last_of_image (last_of_image),
    .overran       (overran)
  );

endmodule : tga_rle_pixel_decoder

`default_nettype wire

>>> rtl/core/trpd_front.sv
// Front end: configuration registers, packet parsing, pixel assembly and image accounting.
`default_nettype none

module trpd_front
  import trpd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  input  wire logic                   full,
  input  wire logic [7:0]             data_byte,
  output logic                        q_push,
  output pixel_entry_t                q_entry
);

  // Configuration state.
  logic        four_byte;
  logic [15:0] width;
  logic [15:0] height;
  logic [31:0] total;

  // Parser state.
  logic        expecting_header;
  logic        run_packet;
  logic [7:0]  packet_left;
  logic [1:0]  byte_position;
  logic [31:0] pixel_assembly;
  logic [31:0] pixels_done;

  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] product;

  logic        accept;
  logic        pixel_complete;
  logic [31:0] pixel_next;
  logic [31:0] remaining;
  logic        remaining_small;
  logic [7:0]  left_nz;
  logic        is_last;
  logic [7:0]  left_after;
  logic [31:0] pixels_done_add;
  logic [7:0]  header_left;

  // The pixel total is refreshed whenever a dimension is written; a zero dimension counts as one.
  always_comb begin
    mul_a = (cfg_index == CFG_WIDTH) ? cfg_data : width;
    mul_b = (cfg_index == CFG_HEIGHT) ? cfg_data : height;
    if (mul_a == 16'd0) begin
      mul_a = 16'd1;
    end
    if (mul_b == 16'd0) begin
      mul_b = 16'd1;
    end
    product = 32'(mul_a) * 32'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      four_byte <= 1'b1;
      width     <= 16'd1;
      height    <= 16'd1;
      total     <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FOUR_BYTE: begin
          four_byte <= cfg_data[0];
        end
        CFG_WIDTH: begin
          width <= cfg_data;
          total <= product;
        end
        CFG_HEIGHT: begin
          height <= cfg_data;
          total  <= product;
        end
        default: begin
        end
      endcase
    end
  end

  // Byte classification and pixel bookkeeping.
  always_comb begin
    accept         = push && !full;
    pixel_complete = four_byte ? (byte_position == 2'd3) : (byte_position >= 2'd2);

    if (byte_position == 2'd0) begin
      pixel_next = {24'd0, data_byte};
    end else begin
      pixel_next = pixel_assembly | ({24'd0, data_byte} << {byte_position, 3'b000});
    end

    header_left = data_byte[7] ? (data_byte - RUN_BIAS) : (data_byte + RAW_BIAS);

    // Pixels still missing from the image; past the total the next pixel closes it.
    remaining       = (pixels_done < total) ? (total - pixels_done) : 32'd1;
    remaining_small = (remaining[31:8] == 24'd0);
    left_nz         = (packet_left == 8'd0) ? 8'd1 : packet_left;

    if (run_packet) begin
      is_last         = remaining_small && (left_nz >= remaining[7:0]);
      left_after      = 8'd0;
      pixels_done_add = pixels_done + {24'd0, left_nz};
    end else begin
      is_last         = (remaining == 32'd1);
      left_after      = left_nz - 8'd1;
      pixels_done_add = pixels_done + 32'd1;
    end

    q_push              = accept && !expecting_header && pixel_complete;
    q_entry.pixel       = pixel_next;
    q_entry.run_packet  = run_packet;
    q_entry.packet_left = left_nz;
    q_entry.last        = is_last;
    q_entry.remain_low  = remaining[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expecting_header <= 1'b1;
      run_packet       <= 1'b0;
      packet_left      <= 8'd0;
      byte_position    <= 2'd0;
      pixels_done      <= 32'd0;
    end else if (accept) begin
      if (expecting_header) begin
        expecting_header <= 1'b0;
        run_packet       <= data_byte[7];
        packet_left      <= header_left;
        byte_position    <= 2'd0;
      end else if (!pixel_complete) begin
        byte_position <= byte_position + 2'd1;
      end else begin
        byte_position <= 2'd0;
        if (is_last) begin
          pixels_done      <= 32'd0;
          expecting_header <= 1'b1;
          packet_left      <= 8'd0;
        end else begin
          pixels_done      <= pixels_done_add;
          packet_left      <= left_after;
          expecting_header <= (left_after == 8'd0);
        end
      end
    end
  end

  // The assembly register is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (accept && !expecting_header) begin
      pixel_assembly <= pixel_next;
    end
  end

endmodule : trpd_front

`default_nettype wire

>>> rtl/core/trpd_queue.sv
// Short first-in first-out queue of assembled pixels between the front end and the output stage.
`default_nettype none

module trpd_queue
  import trpd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  pixel_entry_t      wr_entry,
  output logic              full,
  output logic              rd_valid,
  input  wire logic         rd_en,
  output pixel_entry_t      rd_entry
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pixel_entry_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Status and head of the queue.
  always_comb begin
    full     = (count == CNT_W'(DEPTH));
    rd_valid = (count != '0);
    rd_entry = slots[rd_ptr];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule : trpd_queue

`default_nettype wire

>>> rtl/core/trpd_back.sv
// Output stage: forms the repeat count and clip flag of each pixel and holds the result register.
`default_nettype none

module trpd_back
  import trpd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  output logic              q_take,
  input  pixel_entry_t      q_entry,
  input  wire logic         pop,
  output logic              empty,
  output logic [31:0]       pixel_value,
  output logic [7:0]        repeat_count,
  output logic              last_of_image,
  output logic              overran
);

  logic       out_valid;
  logic [7:0] count;
  logic       over;

  // A raw pixel repeats once; a run repeats its packet count, cut to the pixels still missing.
  always_comb begin
    if (!q_entry.run_packet) begin
      count = 8'd1;
      over  = q_entry.last && (q_entry.packet_left > 8'd1);
    end else begin
      count = q_entry.last ? q_entry.remain_low : q_entry.packet_left;
      over  = q_entry.last && (q_entry.packet_left != q_entry.remain_low);
    end
    q_take = q_valid && (!out_valid || pop);
    empty  = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (q_take) begin
      pixel_value   <= q_entry.pixel;
      repeat_count  <= count;
      last_of_image <= q_entry.last;
      overran       <= over;
    end
  end

endmodule : trpd_back

`default_nettype wire

>>> rtl/core/trpd_checker.sv
// Port-level checker for the TGA run-length pixel decoder and its bind to the top level.
`default_nettype none

module trpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] pixel_value,
  input wire logic [7:0]  repeat_count,
  input wire logic        last_of_image,
  input wire logic        overran
);

  // Reset leaves no result pending.
  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // A repeat count always lies within one packet's span.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (repeat_count != 8'd0 && repeat_count <= 8'd128))
    else $error("repeat count out of range");

  // Clipping only happens on the pixel that closes the image.
  a_over_last : assert property (@(posedge clk) disable iff (rst)
    (!empty && overran) |-> last_of_image)
    else $error("clipped result does not close the image");

  // A waiting result holds until it is taken.
  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_value) && $stable(repeat_count)
                          && $stable(last_of_image) && $stable(overran)))
    else $error("waiting result changed");

endmodule : trpd_checker

bind tga_rle_pixel_decoder trpd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .pixel_value   (pixel_value),
  .repeat_count  (repeat_count),
  .last_of_image (last_of_image),
  .overran       (overran)
);

`default_nettype wire
